@@ rtl/core/dcgw_pkg.sv @@
package dcgw_pkg;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned OffsetW  = 19;
  localparam int unsigned DivisorW = 8;
  localparam int unsigned ZStepW   = 16;
  localparam int unsigned ZW       = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CORNER_OFFSET = 8'd0,
    REG_STEP_DIVISOR  = 8'd1,
    REG_Z_STEP        = 8'd2
  } cfg_reg_e;

  localparam logic [CfgIdxW-1:0]  RegCornerOffsetIdx = REG_CORNER_OFFSET;
  localparam logic [OffsetW-1:0]  CornerOffsetRst    = 19'd4096;
  localparam logic [DivisorW-1:0] StepDivisorRst     = 8'd2;
  localparam logic [ZStepW-1:0]   ZStepRst           = 16'd4096;

  localparam logic [7:0] ChrAUp = 8'h41;
  localparam logic [7:0] ChrALo = 8'h61;
  localparam logic [7:0] ChrCUp = 8'h43;
  localparam logic [7:0] ChrCLo = 8'h63;
  localparam logic [7:0] ChrGUp = 8'h47;
  localparam logic [7:0] ChrGLo = 8'h67;
  localparam logic [7:0] ChrTUp = 8'h54;
  localparam logic [7:0] ChrTLo = 8'h74;
  localparam logic [7:0] ChrGap = 8'h2d;

  typedef enum logic [2:0] {
    COL_RED     = 3'd0,
    COL_GREEN   = 3'd1,
    COL_BLUE    = 3'd2,
    COL_MAGENTA = 3'd3,
    COL_GREY    = 3'd4
  } colour_e;

  typedef enum logic [1:0] {
    KIND_BASE,
    KIND_GAP,
    KIND_JUNK
  } kind_e;

  typedef struct packed {
    kind_e   kind;
    colour_e colour;
    logic    neg_x;
    logic    neg_y;
  } base_dec_t;

  typedef struct packed {
    logic                start;
    logic [DivisorW-1:0] divisor;
  } div_req_t;

  function automatic base_dec_t decode_char(logic [7:0] ch);
    base_dec_t d;
    d = '{kind: KIND_JUNK, colour: COL_RED, neg_x: 1'b0, neg_y: 1'b0};
    case (ch) inside
      ChrAUp, ChrALo: d = '{kind: KIND_BASE, colour: COL_RED,     neg_x: 1'b1, neg_y: 1'b1};
      ChrGUp, ChrGLo: d = '{kind: KIND_BASE, colour: COL_GREEN,   neg_x: 1'b0, neg_y: 1'b1};
      ChrCUp, ChrCLo: d = '{kind: KIND_BASE, colour: COL_BLUE,    neg_x: 1'b1, neg_y: 1'b0};
      ChrTUp, ChrTLo: d = '{kind: KIND_BASE, colour: COL_MAGENTA, neg_x: 1'b0, neg_y: 1'b0};
      ChrGap:         d = '{kind: KIND_GAP,  colour: COL_GREY,    neg_x: 1'b0, neg_y: 1'b0};
      default:        d = '{kind: KIND_JUNK, colour: COL_RED,     neg_x: 1'b0, neg_y: 1'b0};
    endcase
    return d;
  endfunction

endpackage

@@ rtl/core/dcgw_if.sv @@
interface dcgw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_char;
  logic       restart;

  modport source (output valid, output base_char, output restart, input ready);
  modport sink   (input valid, input base_char, input restart, output ready);
endinterface

interface dcgw_out_if #(
  parameter int unsigned COORD_BITS = 20
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic [31:0]                  point_z;
  logic [2:0]                   colour_code;
  logic                         accepted;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output colour_code, output accepted, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  input colour_code, input accepted, output ready);
endinterface

interface dcgw_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/dna_chaos_game_walk_step_unit.sv @@
// DNA chaos-game walk step. One ASCII character per item; A/C/G/T (either case) move
// the kept point (x, y) toward its square corner by (corner - prev) / step_divisor,
// truncated toward zero, and add z_step to z; '-' keeps x, y and adds z_step; any
// other character returns an all-zero result with accepted = 0 and leaves the state
// alone. A base runs the single bit-per-cycle divider once for x and once for y;
// a gap or a rejected character goes straight to the result without the divider.
// The input is not ready while an item is in work. Configuration writes are always
// taken; write them only while idle.
module dna_chaos_game_walk_step_unit #(
  parameter int unsigned COORD_BITS = 20
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  dcgw_in_if.sink     in_if,
  dcgw_out_if.source  out_if,
  dcgw_cfg_if.sink    cfg_if
);
  import dcgw_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam logic [CB-1:0] CoordMax = {1'b0, {(CB-1){1'b1}}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_X,
    S_Y,
    S_DONE
  } state_e;

  state_e state_q;

  logic [OffsetW-1:0]  corner_offset_q;
  logic [DivisorW-1:0] step_divisor_q;
  logic [ZStepW-1:0]   z_step_q;

  logic [CB-1:0] last_x_q, last_y_q;
  logic [ZW-1:0] last_z_q;
  logic [CB-1:0] px_q, py_q, nx_q, ny_q;
  logic [ZW-1:0] nz_q;
  colour_e       colour_q;
  logic          acc_q;
  logic          neg_y_q;
  logic          dneg_q;

  logic          out_valid_q;
  logic [CB-1:0] out_x_q, out_y_q;
  logic [ZW-1:0] out_z_q;
  colour_e       out_colour_q;
  logic          out_acc_q;

  base_dec_t     dec;
  logic          in_fire;
  logic          out_free;
  logic [CB-1:0] in_px, in_py;
  logic [ZW-1:0] in_pz;

  logic [32:0]         g_wide;
  logic [CB-1:0]       g_sat;
  logic [CB-1:0]       prev_sel;
  logic                neg_sel;
  logic signed [CB:0]  corner_s, diff_s, mag_s;
  logic                diff_neg;
  logic [CB-1:0]       dividend;

  div_req_t      div_req;
  logic          div_done;
  logic [CB-1:0] quotient;

  logic [CB-1:0]       step_base;
  logic signed [CB:0]  q_s, sum_s;
  logic [CB-1:0]       step_new;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_free = !out_valid_q || out_if.ready;
  assign dec      = decode_char(in_if.base_char);
  assign in_px    = in_if.restart ? '0 : last_x_q;
  assign in_py    = in_if.restart ? '0 : last_y_q;
  assign in_pz    = in_if.restart ? '0 : last_z_q;

  // Corner distance saturates to the largest positive coordinate.
  always_comb begin
    g_wide = 33'(corner_offset_q);
    g_sat  = (g_wide > 33'(CoordMax)) ? CoordMax : g_wide[CB-1:0];
  end

  // Shared difference path: x straight from the input side, y from the captured prev.
  always_comb begin
    prev_sel = (state_q == S_IDLE) ? in_px : py_q;
    neg_sel  = (state_q == S_IDLE) ? dec.neg_x : neg_y_q;
    corner_s = neg_sel ? -$signed({1'b0, g_sat}) : $signed({1'b0, g_sat});
    diff_s   = corner_s - $signed({prev_sel[CB-1], prev_sel});
    diff_neg = diff_s[CB];
    mag_s    = diff_neg ? -diff_s : diff_s;
    dividend = mag_s[CB-1:0];
  end

  always_comb begin
    div_req.divisor = (step_divisor_q == '0) ? DivisorW'(1) : step_divisor_q;
    div_req.start   = (in_fire && dec.kind == KIND_BASE) || (state_q == S_X && div_done);
  end

  dcgw_div #(
    .W (CB)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (dividend),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Shared step adder: prev plus the signed quotient.
  always_comb begin
    step_base = (state_q == S_X) ? px_q : py_q;
    q_s       = dneg_q ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
    sum_s     = $signed({step_base[CB-1], step_base}) + q_s;
    step_new  = sum_s[CB-1:0];
  end

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_offset_q <= CornerOffsetRst;
      step_divisor_q  <= StepDivisorRst;
      z_step_q        <= ZStepRst;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_CORNER_OFFSET: corner_offset_q <= cfg_if.data[OffsetW-1:0];
        REG_STEP_DIVISOR:  step_divisor_q  <= cfg_if.data[DivisorW-1:0];
        REG_Z_STEP:        z_step_q        <= cfg_if.data[ZStepW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      last_x_q     <= '0;
      last_y_q     <= '0;
      last_z_q     <= '0;
      px_q         <= '0;
      py_q         <= '0;
      nx_q         <= '0;
      ny_q         <= '0;
      nz_q         <= '0;
      colour_q     <= COL_RED;
      acc_q        <= 1'b0;
      neg_y_q      <= 1'b0;
      dneg_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_x_q      <= '0;
      out_y_q      <= '0;
      out_z_q      <= '0;
      out_colour_q <= COL_RED;
      out_acc_q    <= 1'b0;
    end else begin
      // in S_DONE the output register is reloaded below whenever it drains
      if (out_valid_q && out_if.ready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            px_q    <= in_px;
            py_q    <= in_py;
            neg_y_q <= dec.neg_y;
            dneg_q  <= diff_neg;
            case (dec.kind)
              KIND_BASE: begin
                nz_q     <= in_pz + ZW'(z_step_q);
                colour_q <= dec.colour;
                acc_q    <= 1'b1;
                state_q  <= S_X;
              end
              KIND_GAP: begin
                nx_q     <= in_px;
                ny_q     <= in_py;
                nz_q     <= in_pz + ZW'(z_step_q);
                colour_q <= COL_GREY;
                acc_q    <= 1'b1;
                state_q  <= S_DONE;
              end
              default: begin
                nx_q     <= '0;
                ny_q     <= '0;
                nz_q     <= '0;
                colour_q <= COL_RED;
                acc_q    <= 1'b0;
                state_q  <= S_DONE;
              end
            endcase
          end
        end
        S_X: begin
          if (div_done) begin
            nx_q    <= step_new;
            dneg_q  <= diff_neg;
            state_q <= S_Y;
          end
        end
        S_Y: begin
          if (div_done) begin
            ny_q    <= step_new;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_x_q      <= nx_q;
            out_y_q      <= ny_q;
            out_z_q      <= nz_q;
            out_colour_q <= colour_q;
            out_acc_q    <= acc_q;
            if (acc_q) begin
              last_x_q <= nx_q;
              last_y_q <= ny_q;
              last_z_q <= nz_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_if.ready        = (state_q == S_IDLE);
  assign out_if.valid       = out_valid_q;
  assign out_if.point_x     = out_x_q;
  assign out_if.point_y     = out_y_q;
  assign out_if.point_z     = out_z_q;
  assign out_if.colour_code = out_colour_q;
  assign out_if.accepted    = out_acc_q;

  a_div_idle_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !div_done)
    else $error("divider finished outside a step");

  a_accept_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != S_IDLE)
    else $error("accepted item did not start work");

  a_reject_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_acc_q) |->
      (out_x_q == '0 && out_y_q == '0 && out_z_q == '0 && out_colour_q == COL_RED))
    else $error("rejected item carries nonzero fields");

  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result loaded outside the done state");

endmodule

@@ rtl/core/dcgw_div.sv @@
// Restoring divider, one quotient bit per cycle, msb first.
module dcgw_div #(
  parameter int unsigned W = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dcgw_pkg::div_req_t   req_i,
  input  logic [W-1:0]         dividend_i,
  output logic                 done_o,
  output logic [W-1:0]         quotient_o
);
  import dcgw_pkg::*;

  localparam int unsigned CntW = $clog2(W);

  logic [DivisorW-1:0] rem_q, rem_d;
  logic [DivisorW-1:0] div_q;
  logic [W-1:0]        quo_q, quo_d;
  logic [CntW-1:0]     cnt_q;
  logic                busy_q;
  logic                done_q;
  logic [DivisorW:0]   trial;
  logic                ge;

  always_comb begin
    trial = {rem_q, quo_q[W-1]};
    ge    = trial >= {1'b0, div_q};
    rem_d = ge ? DivisorW'(trial - {1'b0, div_q}) : trial[DivisorW-1:0];
    quo_d = {quo_q[W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(W - 1);
        rem_q  <= '0;
        div_q  <= req_i.divisor;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
